>>> design/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

  localparam int LIST_DEPTH_DEF  = 64;
  localparam int BLOCK_BITS_DEF  = 32;
  localparam int NUM_CLASSES_DEF = 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_NO_FRESH = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ASCAN,
    S_SPLIT,
    S_RSTART,
    S_RSCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  size_units;
    logic [31:0] block_addr;
    logic [4:0]  offset_units;
    logic [5:0]  len_units;
    logic        release_direct;
    logic [31:0] fresh_block;
  } bpa_req_t;

  typedef struct packed {
    logic [31:0] piece_block;
    logic [4:0]  piece_offset;
    logic [5:0]  piece_len;
    logic        fresh_used;
    logic        block_freed;
    logic [31:0] freed_block;
    logic        freed_direct;
    logic [1:0]  status;
  } bpa_res_t;

  // Smallest size class whose piece holds len units, capped at the top class nc-1.
  function automatic logic [3:0] class_of(input logic [5:0] len, input int nc);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 7; i++) begin
      if ((int'(c) + 1 < nc) && ({26'd0, len} > (32'd1 << c))) begin
        c = c + 4'd1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> design/bpa_ram.sv
`default_nettype none
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/bpa_ctrl.sv
`default_nettype none
module bpa_ctrl #(
  parameter int LIST_DEPTH  = 64,
  parameter int BLOCK_BITS  = 32,
  parameter int NUM_CLASSES = 5,
  parameter int AW          = 9,
  parameter int DW          = 38
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire bpa_pkg::bpa_req_t req,
  output logic                   idle,
  input  wire logic              res_ready,
  output logic                   done,
  output bpa_pkg::bpa_res_t      res,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [DW-1:0]          mem_wdata,
  output logic [AW-1:0]          mem_raddr,
  input  wire logic [DW-1:0]     mem_rdata
);
  import bpa_pkg::*;

  localparam int JW = $clog2(LIST_DEPTH);
  localparam int NW = $clog2(LIST_DEPTH + 1);
  localparam int CW = $clog2(NUM_CLASSES);
  localparam int KW = $clog2(NUM_CLASSES + 1);
  localparam int BW = BLOCK_BITS;
  localparam int OW = NUM_CLASSES;
  localparam logic [31:0] HALF_U    = 32'd1 << (NUM_CLASSES - 1);
  localparam logic [5:0]  BLOCK_LEN = 6'(1 << NUM_CLASSES);
  localparam logic [KW-1:0] TOP_K   = KW'(NUM_CLASSES);
  localparam logic [KW-1:0] LAST_K  = KW'(NUM_CLASSES - 1);
  localparam logic [NW-1:0] DEPTH_N = NW'(LIST_DEPTH);

  state_t state, state_next;

  logic [NW-1:0] counts [NUM_CLASSES];
  logic          is_alloc;
  logic [KW-1:0] k, c, rc;
  logic [BW-1:0] blk, freg, fblk;
  logic [OW-1:0] offs, roffs;
  logic [5:0]    plen;
  logic          used, rdir, ev_freed, fdir;
  status_t       ev_status;
  logic [NW-1:0] ra;
  logic          pv, space_ok;
  logic [JW-1:0] pj, space;

  logic [63:0] bin_ext, fin_ext, bout_ext, fout_ext;
  logic [15:0] oin_ext, oout_ext;
  logic [BW-1:0] bin, fin;
  logic [OW-1:0] oin;
  logic [5:0]  sz;
  logic [3:0]  c_req_full, c_rel_full;
  logic [KW-1:0] c_req, c_rel;
  logic        alloc_large, rel_large, rel_zero;
  logic [5:0]  len_c;

  logic [CW-1:0] cl;
  logic [NW-1:0] cnt;
  logic          rd_v;
  logic [BW-1:0] rd_blk;
  logic [OW-1:0] rd_offs;
  logic [OW-1:0] bitv, twin;
  logic          scanning, more, issue, scan_end, a_hit, match, r_twin, r_dup, stop;
  state_t        ret_state;

  always_comb begin
    bin_ext = {32'd0, req.block_addr};
    fin_ext = {32'd0, req.fresh_block};
    oin_ext = {11'd0, req.offset_units};
    bin     = bin_ext[BW-1:0];
    fin     = fin_ext[BW-1:0];
    oin     = oin_ext[OW-1:0];
    sz      = (req.size_units == 6'd0) ? 6'd1 : req.size_units;
    alloc_large = {26'd0, sz} > HALF_U;
    rel_large   = {26'd0, req.len_units} > HALF_U;
    rel_zero    = req.len_units == 6'd0;
    c_req_full = class_of(sz, NUM_CLASSES);
    c_rel_full = class_of(req.len_units, NUM_CLASSES);
    c_req   = c_req_full[KW-1:0];
    c_rel   = c_rel_full[KW-1:0];
    len_c   = 6'd1 << c;
  end

  always_comb begin
    cl       = (state == S_ASCAN) ? k[CW-1:0] : rc[CW-1:0];
    cnt      = counts[cl];
    rd_v     = mem_rdata[DW-1];
    rd_blk   = mem_rdata[OW +: BW];
    rd_offs  = mem_rdata[OW-1:0];
    bitv     = OW'(1) << rc;
    twin     = roffs ^ bitv;
    scanning = (state == S_ASCAN) || (state == S_RSCAN);
    more     = ra < cnt;
    a_hit    = (state == S_ASCAN) && pv && rd_v;
    match    = pv && rd_v && (rd_blk == blk);
    r_twin   = (state == S_RSCAN) && match && (rd_offs == twin);
    r_dup    = (state == S_RSCAN) && match && !r_twin && (rd_offs == roffs);
    stop     = a_hit || r_twin || r_dup;
    issue    = scanning && !stop && more;
    scan_end = scanning && !pv && !more;
    ret_state = is_alloc ? S_SPLIT : S_DONE;

    mem_raddr = {cl, ra[JW-1:0]};
    mem_we    = 1'b0;
    mem_waddr = {cl, pj};
    mem_wdata = {1'b0, rd_blk, rd_offs};
    if (a_hit || r_twin) begin
      mem_we = 1'b1;
    end else if ((state == S_RSCAN) && scan_end) begin
      mem_wdata = {1'b1, blk, roffs};
      if (space_ok) begin
        mem_we    = 1'b1;
        mem_waddr = {cl, space};
      end else if (cnt < DEPTH_N) begin
        mem_we    = 1'b1;
        mem_waddr = {cl, cnt[JW-1:0]};
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (req.req_type == REQ_RELEASE) begin
            state_next = (rel_large || rel_zero) ? S_DONE : S_RSTART;
          end else begin
            state_next = alloc_large ? S_DONE : S_ASCAN;
          end
        end
      end
      S_ASCAN: begin
        if (a_hit) begin
          state_next = S_SPLIT;
        end else if (scan_end && (k == LAST_K)) begin
          state_next = (freg == '0) ? S_DONE : S_SPLIT;
        end
      end
      S_SPLIT:  state_next = (k > c) ? S_RSTART : S_DONE;
      S_RSTART: state_next = (rc == TOP_K) ? ret_state : S_RSCAN;
      S_RSCAN: begin
        if (r_twin) begin
          state_next = S_RSTART;
        end else if (r_dup || scan_end) begin
          state_next = ret_state;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        counts[i] <= '0;
      end
      pv <= 1'b0;
      ra <= '0;
    end else begin
      pv <= issue;
      pj <= ra[JW-1:0];
      if (issue) begin
        ra <= ra + NW'(1);
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            is_alloc  <= req.req_type == REQ_ALLOC;
            ev_status <= ST_OK;
            ev_freed  <= 1'b0;
            fblk      <= '0;
            fdir      <= 1'b0;
            used      <= 1'b0;
            plen      <= '0;
            blk       <= '0;
            offs      <= '0;
            freg      <= fin;
            ra        <= '0;
            if (req.req_type == REQ_RELEASE) begin
              blk   <= bin;
              rdir  <= req.release_direct;
              roffs <= oin;
              rc    <= c_rel;
              if (rel_large) begin
                ev_freed <= 1'b1;
                fblk     <= bin;
                fdir     <= req.release_direct;
              end
            end else if (alloc_large) begin
              if (fin == '0) begin
                ev_status <= ST_NO_FRESH;
              end else begin
                blk  <= fin;
                used <= 1'b1;
                plen <= BLOCK_LEN;
              end
            end else begin
              c <= c_req;
              k <= c_req;
            end
          end
        end
        S_ASCAN: begin
          if (a_hit) begin
            blk  <= rd_blk;
            offs <= rd_offs;
            plen <= len_c;
          end else if (scan_end) begin
            k  <= k + KW'(1);
            ra <= '0;
            if (k == LAST_K) begin
              if (freg == '0) begin
                ev_status <= ST_NO_FRESH;
              end else begin
                blk  <= freg;
                offs <= '0;
                used <= 1'b1;
                plen <= len_c;
              end
            end
          end
        end
        S_SPLIT: begin
          if (k > c) begin
            roffs <= offs;
            rc    <= k - KW'(1);
            offs  <= offs + (OW'(1) << (k - KW'(1)));
            k     <= k - KW'(1);
            rdir  <= 1'b1;
          end
        end
        S_RSTART: begin
          if (rc == TOP_K) begin
            if (!ev_freed) begin
              ev_freed <= 1'b1;
              fblk     <= blk;
              fdir     <= rdir;
            end
          end else begin
            ra       <= '0;
            space_ok <= 1'b0;
          end
        end
        S_RSCAN: begin
          if (r_twin) begin
            roffs <= roffs & ~bitv;
            rc    <= rc + KW'(1);
          end else if (r_dup) begin
            if (ev_status == ST_OK) begin
              ev_status <= ST_DUP;
            end
          end else if (pv && !rd_v) begin
            space    <= pj;
            space_ok <= 1'b1;
          end
          if (scan_end && !space_ok) begin
            if (cnt >= DEPTH_N) begin
              if (ev_status == ST_OK) begin
                ev_status <= ST_FULL;
              end
            end else begin
              counts[cl] <= cnt + NW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    idle     = state == S_IDLE;
    done     = (state == S_DONE) && res_ready;
    bout_ext = 64'(blk);
    fout_ext = 64'(fblk);
    oout_ext = 16'(offs);
    res.piece_block  = (is_alloc && plen != '0) ? bout_ext[31:0] : 32'd0;
    res.piece_offset = (is_alloc && plen != '0) ? oout_ext[4:0] : 5'd0;
    res.piece_len    = is_alloc ? plen : 6'd0;
    res.fresh_used   = used;
    res.block_freed  = ev_freed;
    res.freed_block  = fout_ext[31:0];
    res.freed_direct = fdir;
    res.status       = ev_status;
  end

endmodule
`default_nettype wire

>>> design/buddy_piece_allocator.sv
// Buddy allocator for pieces of a 32-unit block, with one free list per size
// class held in a single synchronous memory.
// The input channel (in_valid, in_stall) carries one request per beat: an
// allocate (req_type 0) or a release (req_type 1). Every request gives exactly
// one result beat on the output channel (out_valid, out_stall).
// Requests are handled one at a time. A scan reads at most the list's
// high-water count of entries, since the list memory is read synchronously
// and returns one entry per cycle; each merge or split level passes through
// the restart state before its scan.
// An allocate scans from its class upward and then releases one half per
// split level; a release scans one list per merge level. Requests that need
// no list (whole blocks, zero length) go from idle straight to the done
// state, where the result waits until the output register can take it.
// The result sits in an output register, so a new request is taken while the
// previous result is still stalled; a finished request then waits until the
// register is free. The input is stalled whenever a request is in progress.
// Synchronous reset empties all lists at once through the per-list counts;
// the list memory itself needs no clearing pass.
`default_nettype none
module buddy_piece_allocator #(
  parameter int LIST_DEPTH  = bpa_pkg::LIST_DEPTH_DEF,
  parameter int BLOCK_BITS  = bpa_pkg::BLOCK_BITS_DEF,
  parameter int NUM_CLASSES = bpa_pkg::NUM_CLASSES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [5:0]  size_units,
  input  wire logic [31:0] block_addr,
  input  wire logic [4:0]  offset_units,
  input  wire logic [5:0]  len_units,
  input  wire logic        release_direct,
  input  wire logic [31:0] fresh_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      piece_block,
  output logic [4:0]       piece_offset,
  output logic [5:0]       piece_len,
  output logic             fresh_used,
  output logic             block_freed,
  output logic [31:0]      freed_block,
  output logic             freed_direct,
  output logic [1:0]       status
);
  import bpa_pkg::*;

  localparam int AW = $clog2(NUM_CLASSES) + $clog2(LIST_DEPTH);
  localparam int DW = 1 + BLOCK_BITS + NUM_CLASSES;

  bpa_req_t      req;
  bpa_res_t      res;
  logic          idle, start, done, res_ready;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;

  always_comb begin
    req.req_type       = req_type;
    req.size_units     = size_units;
    req.block_addr     = block_addr;
    req.offset_units   = offset_units;
    req.len_units      = len_units;
    req.release_direct = release_direct;
    req.fresh_block    = fresh_block;
    in_stall  = !idle;
    start     = in_valid && idle;
    res_ready = !out_valid || !out_stall;
  end

  bpa_ctrl #(
    .LIST_DEPTH (LIST_DEPTH),
    .BLOCK_BITS (BLOCK_BITS),
    .NUM_CLASSES(NUM_CLASSES),
    .AW         (AW),
    .DW         (DW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .idle     (idle),
    .res_ready(res_ready),
    .done     (done),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  bpa_ram #(
    .WIDTH(DW),
    .DEPTH(1 << AW)
  ) u_lists (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      piece_block  <= res.piece_block;
      piece_offset <= res.piece_offset;
      piece_len    <= res.piece_len;
      fresh_used   <= res.fresh_used;
      block_freed  <= res.block_freed;
      freed_block  <= res.freed_block;
      freed_direct <= res.freed_direct;
      status       <= res.status;
    end
  end

endmodule
`default_nettype wire

>>> design/bpa_checker.sv
`default_nettype none
module bpa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] piece_block,
  input wire logic [5:0]  piece_len,
  input wire logic        fresh_used,
  input wire logic        block_freed,
  input wire logic [31:0] freed_block,
  input wire logic        freed_direct,
  input wire logic [1:0]  status
);
  import bpa_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output beat present right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(piece_block))
    else $error("Stalled output beat changed.");

  a_freed_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !block_freed |-> freed_block == 32'd0 && !freed_direct)
    else $error("Freed block reported without a freed flag.");

  a_no_fresh: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NO_FRESH |-> piece_len == 6'd0 && !fresh_used)
    else $error("Failed allocate returned a piece.");

  a_fresh_piece: assert property (@(posedge clk) disable iff (rst)
    out_valid && fresh_used |-> piece_len != 6'd0)
    else $error("Fresh block used without a piece.");

endmodule

bind buddy_piece_allocator bpa_checker u_bpa_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .piece_block (piece_block),
  .piece_len   (piece_len),
  .fresh_used  (fresh_used),
  .block_freed (block_freed),
  .freed_block (freed_block),
  .freed_direct(freed_direct),
  .status      (status)
);
`default_nettype wire

>>> sim/buddy_piece_allocator_test.sv
`default_nettype none
module buddy_piece_allocator_test;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = LIST_DEPTH_DEF;
  localparam int NCLS = NUM_CLASSES_DEF;
  localparam int UNITS = 1 << NCLS;
  localparam int HALF = UNITS / 2;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic [5:0] size_units = 6'd1;
  logic [31:0] block_addr = '0;
  logic [4:0] offset_units = '0;
  logic [5:0] len_units = 6'd1;
  logic release_direct = 1'b0;
  logic [31:0] fresh_block = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] piece_block;
  logic [4:0] piece_offset;
  logic [5:0] piece_len;
  logic fresh_used;
  logic block_freed;
  logic [31:0] freed_block;
  logic freed_direct;
  logic [1:0] status;

  buddy_piece_allocator dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow copy of the free lists.
  logic [31:0] list_blk [NCLS][DEPTH];
  logic [4:0] list_off [NCLS][DEPTH];
  bit list_live [NCLS][DEPTH];
  int list_used [NCLS];

  bpa_res_t outcome;
  bpa_res_t pending_results [$];
  int mismatches = 0;
  int results_seen = 0;
  int releases_sent = 0;
  int allocs_sent = 0;
  int idle_cycles = 0;
  bit hold_receiver = 1'b0;
  bit stim_done = 1'b0;

  // Live allocations, used to build well-formed releases.
  logic [31:0] owned_blk [$];
  logic [4:0] owned_off [$];
  logic [5:0] owned_len [$];

  function automatic int size_class(int len);
    int c;
    c = 0;
    while (c + 1 < NCLS && len > (1 << c)) c++;
    return c;
  endfunction

  function automatic void note_status(status_t s);
    if (outcome.status == ST_OK) outcome.status = s;
  endfunction

  function automatic void note_whole(logic [31:0] b, logic d);
    if (!outcome.block_freed) begin
      outcome.block_freed = 1'b1;
      outcome.freed_block = b;
      outcome.freed_direct = d;
    end
  endfunction

  function automatic void free_piece(logic [31:0] b, int offs, int len, logic d);
    int c;
    int twin;
    int spot;
    bit joined;
    if (len == 0) return;
    if (len <= HALF) len = 1 << size_class(len);
    offs = offs & (UNITS - 1);
    forever begin
      if (len > HALF) begin
        note_whole(b, d);
        return;
      end
      c = size_class(len);
      twin = ((offs / len) & 1) ? offs - len : offs + len;
      spot = -1;
      joined = 0;
      for (int j = 0; j < list_used[c]; j++) begin
        if (list_live[c][j] && list_blk[c][j] == b) begin
          if (int'(list_off[c][j]) == twin) begin
            list_live[c][j] = 0;
            if (twin < offs) offs = twin;
            len = len << 1;
            joined = 1;
            break;
          end else if (int'(list_off[c][j]) == offs) begin
            note_status(ST_DUP);
            return;
          end
        end else if (!list_live[c][j]) begin
          spot = j;
        end
      end
      if (!joined) begin
        if (spot < 0) begin
          if (list_used[c] >= DEPTH) begin
            note_status(ST_FULL);
            return;
          end
          spot = list_used[c];
          list_used[c]++;
        end
        list_blk[c][spot] = b;
        list_off[c][spot] = offs[4:0];
        list_live[c][spot] = 1;
        return;
      end
    end
  endfunction

  function automatic bpa_res_t allocator_outcome(bpa_req_t r);
    int sz, c, k, offs, len;
    bit found;
    outcome = '0;
    if (r.req_type == REQ_RELEASE) begin
      if (r.len_units > HALF) note_whole(r.block_addr, r.release_direct);
      else free_piece(r.block_addr, r.offset_units, r.len_units, r.release_direct);
      return outcome;
    end
    sz = (r.size_units == 0) ? 1 : int'(r.size_units);
    if (sz > HALF) begin
      if (r.fresh_block == 0) outcome.status = ST_NO_FRESH;
      else begin
        outcome.piece_block = r.fresh_block;
        outcome.piece_len = UNITS;
        outcome.fresh_used = 1'b1;
      end
      return outcome;
    end
    c = size_class(sz);
    k = c;
    found = 0;
    offs = 0;
    len = 0;
    while (k < NCLS && !found) begin
      for (int j = 0; j < list_used[k]; j++) begin
        if (list_live[k][j]) begin
          outcome.piece_block = list_blk[k][j];
          offs = list_off[k][j];
          len = 1 << k;
          list_live[k][j] = 0;
          found = 1;
          break;
        end
      end
      if (!found) k++;
    end
    if (!found) begin
      if (r.fresh_block == 0) begin
        outcome.status = ST_NO_FRESH;
        return outcome;
      end
      outcome.piece_block = r.fresh_block;
      len = UNITS;
      outcome.fresh_used = 1'b1;
    end
    while (k > c) begin
      len = len >> 1;
      free_piece(outcome.piece_block, offs, len, 1'b1);
      offs += len;
      k--;
    end
    outcome.piece_offset = offs[4:0];
    outcome.piece_len = len[5:0];
    return outcome;
  endfunction

  task automatic send_beat(bpa_req_t r);
    req_type <= r.req_type;
    size_units <= r.size_units;
    block_addr <= r.block_addr;
    offset_units <= r.offset_units;
    len_units <= r.len_units;
    release_direct <= r.release_direct;
    fresh_block <= r.fresh_block;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(allocator_outcome(r));
    if (r.req_type == REQ_RELEASE) releases_sent++;
    else allocs_sent++;
  endtask

  task automatic pause_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic bpa_req_t make_alloc(int sz, logic [31:0] fresh);
    bpa_req_t r;
    r = '0;
    r.req_type = REQ_ALLOC;
    r.size_units = sz[5:0];
    r.fresh_block = fresh;
    r.block_addr = $urandom;
    r.offset_units = $urandom;
    r.len_units = $urandom;
    r.release_direct = $urandom;
    return r;
  endfunction

  function automatic bpa_req_t make_release(logic [31:0] b, int offs, int len, logic d);
    bpa_req_t r;
    r = '0;
    r.req_type = REQ_RELEASE;
    r.block_addr = b;
    r.offset_units = offs[4:0];
    r.len_units = len[5:0];
    r.release_direct = d;
    r.size_units = $urandom;
    r.fresh_block = $urandom;
    return r;
  endfunction

  // Directed rows: request plus, where obvious, the result it must give.
  typedef struct {
    bpa_req_t req;
    bit known;
    bpa_res_t res;
  } directed_row_t;

  directed_row_t directed_rows [$];

  task automatic add_row(bpa_req_t r, bit known, bpa_res_t res);
    directed_row_t row;
    row.req = r;
    row.known = known;
    row.res = res;
    directed_rows.push_back(row);
  endtask

  function automatic bpa_res_t res_of(logic [31:0] pb, int po, int pl, logic fu, logic bf,
                                      logic [31:0] fb, logic fd, status_t st);
    bpa_res_t x;
    x.piece_block = pb;
    x.piece_offset = po[4:0];
    x.piece_len = pl[5:0];
    x.fresh_used = fu;
    x.block_freed = bf;
    x.freed_block = fb;
    x.freed_direct = fd;
    x.status = st;
    return x;
  endfunction

  // Stimulus.
  initial begin
    bpa_req_t r;
    bpa_res_t want;
    int pick, sz, offs, len;
    logic [31:0] b;
    for (int c = 0; c < NCLS; c++) list_used[c] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(make_alloc(1, 0), 1, res_of(0, 0, 0, 0, 0, 0, 0, ST_NO_FRESH));
    add_row(make_alloc(32, 32'hFFFF_FFFF), 1,
            res_of(32'hFFFF_FFFF, 0, 32, 1, 0, 0, 0, ST_OK));
    add_row(make_alloc(63, 32'h0000_0001), 1, res_of(1, 0, 32, 1, 0, 0, 0, ST_OK));
    add_row(make_alloc(17, 0), 1, res_of(0, 0, 0, 0, 0, 0, 0, ST_NO_FRESH));
    add_row(make_release(32'hFFFF_FFFF, 31, 63, 1), 1,
            res_of(0, 0, 0, 0, 1, 32'hFFFF_FFFF, 1, ST_OK));
    add_row(make_release(32'h1234_5678, 0, 0, 1), 1, res_of(0, 0, 0, 0, 0, 0, 0, ST_OK));
    add_row(make_alloc(0, 32'h0000_0010), 0, want);
    add_row(make_alloc(1, 32'h0000_0020), 0, want);
    add_row(make_alloc(2, 0), 0, want);
    add_row(make_alloc(3, 0), 0, want);
    add_row(make_alloc(16, 32'h0000_0030), 0, want);
    add_row(make_release(32'h0000_0010, 0, 1, 0), 0, want);
    add_row(make_release(32'h0000_0010, 0, 1, 0), 0, want);
    add_row(make_release(32'h0000_0010, 1, 1, 0), 0, want);
    add_row(make_release(32'h0000_0020, 2, 3, 1), 0, want);
    add_row(make_release(32'h0000_0030, 16, 16, 0), 0, want);
    add_row(make_release(32'h8000_0000, 7, 5, 1), 0, want);
    add_row(make_release(32'h8000_0000, 31, 16, 0), 0, want);
    add_row(make_release(32'h0000_0020, 1, 1, 1), 0, want);
    add_row(make_alloc(8, 32'h0000_0040), 0, want);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].req);
      if (directed_rows[i].known && pending_results[$] != directed_rows[i].res) begin
        mismatches++;
        $display("directed row %0d predicts %p, table says %p", i, pending_results[$],
                 directed_rows[i].res);
      end
    end
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);

    // Long receiver hold-off while requests keep coming.
    hold_receiver = 1'b1;
    for (int i = 0; i < 6; i++) send_beat(make_alloc($urandom_range(1, 16), 32'h100 + i));
    hold_receiver = 1'b0;

    // Fill one list to its limit with pieces from distinct blocks.
    for (int i = 0; i < DEPTH + 4; i++)
      send_beat(make_release(32'h5000_0000 + i, 0, 1, $urandom));
    pause_sender(1);
    wait (pending_results.size() == 0);
    @(posedge clk);
    for (int i = 0; i < DEPTH + 4; i++) send_beat(make_alloc(1, 0));

    for (int i = 0; i < 830; i++) begin
      if ($urandom_range(0, 9) == 0) pause_sender($urandom_range(1, 12));
      if ($urandom_range(0, 199) == 0) begin
        pause_sender(1);
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        sz = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 16);
        b = ($urandom_range(0, 9) == 0) ? 32'd0 :
            ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(1, 12);
        r = make_alloc(sz, b);
        send_beat(r);
        if (pending_results[$].piece_len != 0 && pending_results[$].piece_len <= HALF) begin
          owned_blk.push_back(pending_results[$].piece_block);
          owned_off.push_back(pending_results[$].piece_offset);
          owned_len.push_back(pending_results[$].piece_len);
        end
      end else if (pick < 90 && owned_blk.size() > 0) begin
        offs = $urandom_range(0, owned_blk.size() - 1);
        r = make_release(owned_blk[offs], owned_off[offs], owned_len[offs], $urandom);
        if ($urandom_range(0, 9) != 0) begin
          owned_blk.delete(offs);
          owned_off.delete(offs);
          owned_len.delete(offs);
        end
        send_beat(r);
      end else begin
        len = $urandom_range(0, 63);
        b = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 12) : $urandom;
        send_beat(make_release(b, $urandom_range(0, 31), len, $urandom));
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: its own stall pattern, plus a long counted hold-off.
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
        out_stall <= 1'b0;
        wait (!hold_receiver);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b0;
      end else begin
        case ($urandom_range(0, 2))
          0: out_stall <= 1'b1;
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    bpa_res_t got;
    bpa_res_t exp_res;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        got = {piece_block, piece_offset, piece_len, fresh_used, block_freed,
               freed_block, freed_direct, status};
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", got);
        end else begin
          exp_res = pending_results.pop_front();
          if (got != exp_res) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p, got %p", exp_res, got);
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done && pending_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("Covered %0d allocates and %0d releases, %0d result beats checked.",
             allocs_sent, releases_sent, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog expired with %0d results outstanding.", pending_results.size());
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
design/bpa_pkg.sv
design/bpa_ram.sv
design/bpa_ctrl.sv
design/buddy_piece_allocator.sv
design/bpa_checker.sv
sim/buddy_piece_allocator_test.sv
